// ----- design/ffha_pkg.sv -----
// Shared constants, codes and controller/datapath interface types of the heap allocator.
package ffha_pkg;

   localparam int unsigned ARENA_GRANULES_DEF  = 1024;
   localparam int unsigned HEADER_GRANULES_DEF = 3;

   localparam int unsigned SIZE_W   = 13;
   localparam int unsigned ADDR_W   = 12;
   localparam int unsigned STATUS_W = 2;

   // largest rounded request in granules
   localparam int unsigned MAX_NEED = 2 ** (SIZE_W - 2);

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOFIT    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

   localparam logic [1:0] RES_OK_ALLOC = 2'd0;
   localparam logic [1:0] RES_NOFIT    = 2'd1;
   localparam logic [1:0] RES_BAD_FREE = 2'd2;
   localparam logic [1:0] RES_OK_FREE  = 2'd3;

   typedef struct packed {
      logic       load;
      logic       clr_write;
      logic       walk_start;
      logic       walk_step;
      logic       alloc_commit;
      logic       split_commit;
      logic       free_read_hdr;
      logic       free_open;
      logic       free_merge;
      logic       finish;
      logic [1:0] result;
   } ctrl_cmd_type;

   typedef struct packed {
      logic new_free;
      logic clr_last;
      logic size_zero;
      logic free_addr_bad;
      logic mark;
      logic walk_bad;
      logic walk_fit;
      logic walk_split;
      logic walk_end;
      logic link_in_arena;
      logic nxt_in_arena;
      logic rd_used;
   } dp_status_type;

endpackage

// ----- design/ffha_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
module ffha_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/ffha_dp.sv -----
// Datapath: header RAM, walk cursor, fit and split arithmetic, request and result registers.
module ffha_dp #(
   parameter int unsigned ARENA_GRANULES  = ffha_pkg::ARENA_GRANULES_DEF,
   parameter int unsigned HEADER_GRANULES = ffha_pkg::HEADER_GRANULES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_command,
   input  logic [ffha_pkg::SIZE_W-1:0]   req_size_bytes,
   input  logic [ffha_pkg::ADDR_W-1:0]   req_data_address,
   input  ffha_pkg::ctrl_cmd_type        cmd,
   output ffha_pkg::dp_status_type       stat,
   output logic                          rsp_strobe,
   output logic [ffha_pkg::STATUS_W-1:0] rsp_status,
   output logic [ffha_pkg::ADDR_W-1:0]   rsp_result_address
);

   localparam int unsigned GW = $clog2(ARENA_GRANULES);
   localparam int unsigned LW = $clog2(ARENA_GRANULES + 1);
   localparam int unsigned TW = $clog2(ffha_pkg::MAX_NEED + HEADER_GRANULES + 1);
   localparam int unsigned CW = ((LW > TW) ? LW : TW) + 1;
   localparam int unsigned GRAN_W = ffha_pkg::ADDR_W - 2;
   localparam int unsigned FW = ((LW > GRAN_W) ? LW : GRAN_W) + 1;
   localparam int unsigned AW = ((GW > GRAN_W) ? GW : GRAN_W) + 1;
   localparam int unsigned RW = LW + 2;

   // entry layout: mark, in-use, link
   logic          ram_we;
   logic [GW-1:0] ram_waddr;
   logic [RW-1:0] ram_wdata;
   logic [GW-1:0] ram_raddr;
   logic [RW-1:0] ram_rdata;

   logic          rd_mark;
   logic          rd_used;
   logic [LW-1:0] rd_link;

   logic [ffha_pkg::SIZE_W-1:0] size_ff;
   logic [ffha_pkg::ADDR_W-1:0] addr_ff;
   logic [TW-1:0]               tot_ff;
   logic [TW-1:0]               tot_in;
   logic [GW-1:0]               cur_ff;
   logic [GW-1:0]               clr_ff;
   logic [GW-1:0]               split_ff;
   logic                        mark_ff;
   logic [LW-1:0]               nxt_ff;

   logic [ffha_pkg::SIZE_W:0] size_up;
   logic [CW-1:0]             cur_w;
   logic [CW-1:0]             nxt_w;
   logic [CW-1:0]             span;
   logic [CW-1:0]             rest;
   logic [CW-1:0]             split_w;
   logic [FW-1:0]             gran_w;
   logic [FW-1:0]             hdr_w;
   logic [GW-1:0]             hdr_idx;
   logic [AW-1:0]             data_gran;

   logic                        rsp_strobe_ff;
   logic [ffha_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [ffha_pkg::ADDR_W-1:0]   rsp_addr_ff;
   logic [ffha_pkg::STATUS_W-1:0] rsp_status_in;
   logic [ffha_pkg::ADDR_W-1:0]   rsp_addr_in;

   ffha_ram #(
      .WIDTH (RW),
      .DEPTH (ARENA_GRANULES)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_mark = ram_rdata[LW+1];
   assign rd_used = ram_rdata[LW];
   assign rd_link = ram_rdata[LW-1:0];

   assign size_up = {1'b0, req_size_bytes} + (ffha_pkg::SIZE_W + 1)'(3);
   assign tot_in  = TW'(size_up[ffha_pkg::SIZE_W:2]) + TW'(HEADER_GRANULES);

   // walk arithmetic on the header just read
   assign cur_w   = CW'(cur_ff);
   assign nxt_w   = CW'(rd_link);
   assign span    = nxt_w - cur_w;
   assign rest    = span - CW'(tot_ff);
   assign split_w = cur_w + CW'(tot_ff);

   // free address decode
   assign gran_w  = FW'(addr_ff[ffha_pkg::ADDR_W-1:2]);
   assign hdr_w   = gran_w - FW'(HEADER_GRANULES);
   assign hdr_idx = hdr_w[GW-1:0];

   assign data_gran = AW'(cur_ff) + AW'(HEADER_GRANULES);

   always_comb begin
      stat               = '0;
      stat.new_free      = req_command;
      stat.clr_last      = (clr_ff == GW'(ARENA_GRANULES - 1));
      stat.size_zero     = (size_ff == '0);
      stat.free_addr_bad = (addr_ff == '0) || (addr_ff[1:0] != 2'b00)
                           || (gran_w < FW'(HEADER_GRANULES))
                           || (hdr_w >= FW'(ARENA_GRANULES));
      stat.mark          = rd_mark;
      stat.walk_bad      = (nxt_w <= cur_w) || (nxt_w > CW'(ARENA_GRANULES));
      stat.walk_fit      = !rd_used && (span >= CW'(tot_ff));
      stat.walk_split    = (rest >= CW'(HEADER_GRANULES + 1));
      stat.walk_end      = (nxt_w == CW'(ARENA_GRANULES));
      stat.link_in_arena = (rd_link < LW'(ARENA_GRANULES));
      stat.nxt_in_arena  = (nxt_ff < LW'(ARENA_GRANULES));
      stat.rd_used       = rd_used;
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      ram_raddr = '0;
      if (cmd.clr_write) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = (clr_ff == '0) ? {1'b1, 1'b0, LW'(ARENA_GRANULES)} : '0;
      end
      if (cmd.alloc_commit) begin
         ram_we = 1'b1;
         if (stat.walk_split) begin
            ram_waddr = split_w[GW-1:0];
            ram_wdata = {1'b1, 1'b0, rd_link};
         end else begin
            ram_waddr = cur_ff;
            ram_wdata = {rd_mark, 1'b1, rd_link};
         end
      end
      if (cmd.split_commit) begin
         ram_we    = 1'b1;
         ram_waddr = cur_ff;
         ram_wdata = {mark_ff, 1'b1, LW'(split_ff)};
      end
      if (cmd.free_open || cmd.free_merge) begin
         ram_we    = 1'b1;
         ram_waddr = hdr_idx;
         ram_wdata = {1'b1, 1'b0, rd_link};
      end
      if (cmd.walk_step || cmd.free_open) begin
         ram_raddr = rd_link[GW-1:0];
      end
      if (cmd.free_read_hdr) begin
         ram_raddr = hdr_idx;
      end
   end

   always_comb begin
      rsp_status_in = ffha_pkg::ST_OK;
      rsp_addr_in   = '0;
      case (cmd.result)
         ffha_pkg::RES_OK_ALLOC: begin
            rsp_addr_in = {data_gran[GRAN_W-1:0], 2'b00};
         end
         ffha_pkg::RES_NOFIT: begin
            rsp_status_in = ffha_pkg::ST_NOFIT;
         end
         ffha_pkg::RES_BAD_FREE: begin
            rsp_status_in = ffha_pkg::ST_BAD_FREE;
            rsp_addr_in   = addr_ff;
         end
         default: begin
            rsp_status_in = ffha_pkg::ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.finish;
         if (cmd.clr_write) begin
            clr_ff <= clr_ff + GW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         size_ff <= req_size_bytes;
         addr_ff <= req_data_address;
         tot_ff  <= tot_in;
      end
      if (cmd.walk_start) begin
         cur_ff <= '0;
      end
      if (cmd.walk_step) begin
         cur_ff <= rd_link[GW-1:0];
      end
      if (cmd.alloc_commit) begin
         mark_ff  <= rd_mark;
         split_ff <= split_w[GW-1:0];
      end
      if (cmd.free_open) begin
         nxt_ff <= rd_link;
      end
      if (cmd.finish) begin
         rsp_status_ff <= rsp_status_in;
         rsp_addr_ff   <= rsp_addr_in;
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_address = rsp_addr_ff;

endmodule

// ----- design/ffha_ctrl.sv -----
// Controller: clearing pass, allocate walk sequencing and free sequencing.
module ffha_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  ffha_pkg::dp_status_type stat,
   output ffha_pkg::ctrl_cmd_type  cmd
);

   localparam logic [2:0] S_CLEAR    = 3'd0;
   localparam logic [2:0] S_IDLE     = 3'd1;
   localparam logic [2:0] S_ALLOC    = 3'd2;
   localparam logic [2:0] S_WALK     = 3'd3;
   localparam logic [2:0] S_SPLIT    = 3'd4;
   localparam logic [2:0] S_FREE     = 3'd5;
   localparam logic [2:0] S_FREE_HDR = 3'd6;
   localparam logic [2:0] S_FREE_NXT = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = stat.new_free ? S_FREE : S_ALLOC;
            end
         end
         S_ALLOC: begin
            if (stat.size_zero) begin
               cmd.finish = 1'b1;
               cmd.result = ffha_pkg::RES_NOFIT;
               state_in   = S_IDLE;
            end else begin
               cmd.walk_start = 1'b1;
               state_in       = S_WALK;
            end
         end
         S_WALK: begin
            if (stat.walk_bad) begin
               cmd.finish = 1'b1;
               cmd.result = ffha_pkg::RES_NOFIT;
               state_in   = S_IDLE;
            end else if (stat.walk_fit) begin
               cmd.alloc_commit = 1'b1;
               if (stat.walk_split) begin
                  state_in = S_SPLIT;
               end else begin
                  cmd.finish = 1'b1;
                  cmd.result = ffha_pkg::RES_OK_ALLOC;
                  state_in   = S_IDLE;
               end
            end else if (stat.walk_end) begin
               cmd.finish = 1'b1;
               cmd.result = ffha_pkg::RES_NOFIT;
               state_in   = S_IDLE;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         S_SPLIT: begin
            cmd.split_commit = 1'b1;
            cmd.finish       = 1'b1;
            cmd.result       = ffha_pkg::RES_OK_ALLOC;
            state_in         = S_IDLE;
         end
         S_FREE: begin
            if (stat.free_addr_bad) begin
               cmd.finish = 1'b1;
               cmd.result = ffha_pkg::RES_BAD_FREE;
               state_in   = S_IDLE;
            end else begin
               cmd.free_read_hdr = 1'b1;
               state_in          = S_FREE_HDR;
            end
         end
         S_FREE_HDR: begin
            if (!stat.mark) begin
               cmd.finish = 1'b1;
               cmd.result = ffha_pkg::RES_BAD_FREE;
               state_in   = S_IDLE;
            end else begin
               // clear in-use now; the next header is read in the same cycle
               cmd.free_open = 1'b1;
               if (stat.link_in_arena) begin
                  state_in = S_FREE_NXT;
               end else begin
                  cmd.finish = 1'b1;
                  cmd.result = ffha_pkg::RES_OK_FREE;
                  state_in   = S_IDLE;
               end
            end
         end
         S_FREE_NXT: begin
            cmd.free_merge = stat.nxt_in_arena && !stat.rd_used;
            cmd.finish     = 1'b1;
            cmd.result     = ffha_pkg::RES_OK_FREE;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ----- design/first_fit_heap_allocator.sv -----
// Top level of the first-fit heap allocator: controller plus datapath.
//
//   channel   direction  handshake            ports
//   request   in         start & !busy        req_command, req_size_bytes, req_data_address
//   response  out        rsp_strobe, 1 cycle  rsp_status, rsp_result_address
//
// Allocate loads the request and walks the block headers (one header RAM read per cycle),
// plus a header write when the chosen block is split. Free may merge with the next block.
// The response word is shown the cycle after the last step; busy drops at the same time.
// After reset a clearing pass writes every header entry, with busy high.
// The receiver cannot stall: every response word is taken in its strobe cycle.
module first_fit_heap_allocator #(
   parameter int unsigned ARENA_GRANULES  = ffha_pkg::ARENA_GRANULES_DEF,
   parameter int unsigned HEADER_GRANULES = ffha_pkg::HEADER_GRANULES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_command,
   input  logic [ffha_pkg::SIZE_W-1:0]   req_size_bytes,
   input  logic [ffha_pkg::ADDR_W-1:0]   req_data_address,
   output logic                          rsp_strobe,
   output logic [ffha_pkg::STATUS_W-1:0] rsp_status,
   output logic [ffha_pkg::ADDR_W-1:0]   rsp_result_address
);

   ffha_pkg::ctrl_cmd_type  cmd;
   ffha_pkg::dp_status_type stat;

   ffha_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   ffha_dp #(
      .ARENA_GRANULES  (ARENA_GRANULES),
      .HEADER_GRANULES (HEADER_GRANULES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_command        (req_command),
      .req_size_bytes     (req_size_bytes),
      .req_data_address   (req_data_address),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_result_address (rsp_result_address)
   );

endmodule

// ----- design/ffha_chk.sv -----
// Port-level checker for the heap allocator, bound to the top level.
module ffha_chk (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_strobe,
   input logic [ffha_pkg::STATUS_W-1:0] rsp_status,
   input logic [ffha_pkg::ADDR_W-1:0]   rsp_result_address
);

   // an accepted word keeps the block busy on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not make the block busy");

   // a response only closes work in progress
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response without preceding work");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_status == ffha_pkg::ST_OK || rsp_status == ffha_pkg::ST_NOFIT
                      || rsp_status == ffha_pkg::ST_BAD_FREE))
      else $error("undefined response status");

   a_nofit_null: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == ffha_pkg::ST_NOFIT |-> rsp_result_address == '0)
      else $error("failed allocate returned a non-null address");

   a_ok_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == ffha_pkg::ST_OK |-> rsp_result_address[1:0] == 2'b00)
      else $error("successful response address not word aligned");

endmodule

bind first_fit_heap_allocator ffha_chk u_ffha_chk (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_strobe         (rsp_strobe),
   .rsp_status         (rsp_status),
   .rsp_result_address (rsp_result_address)
);
